@@ rtl/core/mrsp_pkg.sv @@
package mrsp_pkg;

  localparam int NUM_PORTS = 4;
  localparam int PORT_W = 2;
  localparam logic [PORT_W:0] PORT_LIMIT = NUM_PORTS[PORT_W:0];

  localparam logic [3:0] ST_NONE       = 4'h0;
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_POLY_PRESS = 4'hA;
  localparam logic [3:0] ST_CONTROL    = 4'hB;
  localparam logic [3:0] ST_PROGRAM    = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_PITCH      = 4'hE;
  localparam logic [3:0] ST_SYSTEM     = 4'hF;

  localparam logic [2:0] KIND_PROGRAM    = 3'd4;
  localparam logic [2:0] KIND_CHAN_PRESS = 3'd5;

  localparam logic [7:0] BYTE_EOX = 8'hF7;

  localparam logic [1:0] LEN_SHORT = 2'd2;
  localparam logic [1:0] LEN_LONG  = 2'd3;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [7:0]        rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [PORT_W-1:0] src_port;
    logic [2:0]        msg_kind;
    logic [3:0]        chan;
    logic [6:0]        data_one;
    logic [6:0]        data_two;
    logic [1:0]        msg_len;
    logic [15:0]       seq_num;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  run_status;
    logic [3:0]  run_chan;
    logic        pend_valid;
    logic [6:0]  pend_byte;
    logic [15:0] seq_count;
  } entry_t;

  typedef struct packed {
    entry_t    nxt;
    logic      emit;
    out_word_t msg;
  } step_t;

endpackage

@@ rtl/core/mrsp_step.sv @@
module mrsp_step import mrsp_pkg::*; (
  input  entry_t            cur,
  input  logic [PORT_W-1:0] port,
  input  logic [7:0]        rx_byte,
  output step_t             res
);

  always_comb begin
    res              = '0;
    res.nxt          = cur;
    res.msg.src_port = port;
    res.msg.msg_kind = cur.run_status[2:0];
    res.msg.chan     = cur.run_chan;
    res.msg.seq_num  = cur.seq_count;
    if (rx_byte[7]) begin
      res.nxt.run_chan   = rx_byte[3:0];
      res.nxt.run_status = (rx_byte == BYTE_EOX) ? ST_NONE : rx_byte[7:4];
      res.nxt.pend_valid = 1'b0;
    end else begin
      unique case (cur.run_status)
        ST_PROGRAM, ST_CHAN_PRESS: begin
          res.emit          = 1'b1;
          res.msg.data_one  = rx_byte[6:0];
          res.msg.data_two  = 7'd0;
          res.msg.msg_len   = LEN_SHORT;
          res.nxt.seq_count = cur.seq_count + 16'd1;
        end
        ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CONTROL, ST_PITCH: begin
          if (cur.pend_valid) begin
            res.emit           = 1'b1;
            res.msg.data_one   = cur.pend_byte;
            res.msg.data_two   = rx_byte[6:0];
            res.msg.msg_len    = LEN_LONG;
            res.nxt.pend_valid = 1'b0;
            res.nxt.seq_count  = cur.seq_count + 16'd1;
          end else begin
            res.nxt.pend_byte  = rx_byte[6:0];
            res.nxt.pend_valid = 1'b1;
          end
        end
        default: begin
          res.emit = 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/midi_running_status_parser_unit.sv @@
// MIDI byte parser with per-port running status.
// Input channel byte_*: one received byte and its port per word.
// Output channel msg_*: one completed channel message per word, with its
// length and a per-port 16-bit wrapping sequence number.
// Per-port state sits in a small synchronous memory. The entry is read at
// the edge that accepts a byte, updated in the following cycle and written
// back at the edge that moves the byte on; a byte for the same port right behind takes the
// updated entry through a forwarding path.
// Throughput: one byte per cycle while no completing byte waits on a full
// output register. msg_valid rises at the edge that moves the completing byte on.
// Status bytes and incomplete messages produce no word.
// Reset clears every port's status, pending byte and sequence count at once
// through per-entry valid bits; byte_ready is high again as soon as reset
// falls.
// When msg_ready is low the output register holds its word; the byte in
// flight still advances if it completes nothing, otherwise byte_ready drops
// until the output register frees.
module midi_running_status_parser_unit import mrsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_word_t  byte_word,
  output logic      msg_valid,
  input  logic      msg_ready,
  output out_word_t msg_word
);

  entry_t               mem [NUM_PORTS];
  logic [NUM_PORTS-1:0] ent_valid;

  logic     s1_valid;
  in_word_t s1_word;
  entry_t   rd_raw;
  logic     rd_valid;
  logic     fwd_hit;
  entry_t   fwd_entry;

  entry_t cur;
  step_t  step;
  logic   s1_in_range;
  logic   s1_emit;
  logic   go;
  logic   take;

  assign cur = fwd_hit ? fwd_entry : (rd_valid ? rd_raw : '0);
  assign s1_in_range = ({1'b0, s1_word.port} < PORT_LIMIT);
  assign s1_emit = s1_valid && s1_in_range && step.emit;
  assign go = s1_valid && (!s1_emit || !msg_valid || msg_ready);
  assign byte_ready = !s1_valid || go;
  assign take = byte_valid && byte_ready;

  mrsp_step u_step (
    .cur     (cur),
    .port    (s1_word.port),
    .rx_byte (s1_word.rx_byte),
    .res     (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      msg_valid <= 1'b0;
      ent_valid <= '0;
    end else begin
      if (byte_ready) begin
        s1_valid <= byte_valid;
      end
      if (go && s1_emit) begin
        msg_valid <= 1'b1;
      end else if (msg_ready) begin
        msg_valid <= 1'b0;
      end
      if (go && s1_in_range) begin
        ent_valid[s1_word.port] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_word   <= byte_word;
      rd_raw    <= mem[byte_word.port];
      rd_valid  <= ent_valid[byte_word.port];
      fwd_hit   <= go && s1_in_range && (s1_word.port == byte_word.port);
      fwd_entry <= step.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1_in_range) begin
      mem[s1_word.port] <= step.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1_emit) begin
      msg_word <= step.msg;
    end
  end

endmodule

@@ rtl/core/mrsp_checker.sv @@
module mrsp_checker import mrsp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      byte_valid,
  input logic      byte_ready,
  input in_word_t  byte_word,
  input logic      msg_valid,
  input logic      msg_ready,
  input out_word_t msg_word
);

  logic unused_in;
  assign unused_in = byte_valid ^ byte_ready ^ (^byte_word);

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    msg_valid |-> (msg_word.msg_len == LEN_SHORT || msg_word.msg_len == LEN_LONG))
    else $error("message length out of range");

  a_len_kind: assert property (@(posedge clk) disable iff (rst)
    msg_valid |-> ((msg_word.msg_kind == KIND_PROGRAM ||
                    msg_word.msg_kind == KIND_CHAN_PRESS)
                   == (msg_word.msg_len == LEN_SHORT)))
    else $error("message length does not match kind");

  a_short_data: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_word.msg_len == LEN_SHORT |-> msg_word.data_two == 7'd0)
    else $error("short message carries second data byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_ready |=> msg_valid && $stable(msg_word))
    else $error("stalled message word changed");

endmodule

bind midi_running_status_parser_unit mrsp_checker u_mrsp_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_ready (byte_ready),
  .byte_word  (byte_word),
  .msg_valid  (msg_valid),
  .msg_ready  (msg_ready),
  .msg_word   (msg_word)
);

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mrsp_pkg::*;

  class msg_scoreboard;
    logic [3:0]  run_status [NUM_PORTS];
    logic [3:0]  run_chan   [NUM_PORTS];
    logic        pend_valid [NUM_PORTS];
    logic [6:0]  pend_byte  [NUM_PORTS];
    logic [15:0] seq_count  [NUM_PORTS];
    out_word_t   expected_msgs [$];
    int          errors;

    function new();
      for (int i = 0; i < NUM_PORTS; i++) begin
        run_status[i] = ST_NONE;
        run_chan[i]   = '0;
        pend_valid[i] = 1'b0;
        pend_byte[i]  = '0;
        seq_count[i]  = '0;
      end
      errors = 0;
    endfunction

    function void push_msg(int unsigned p, logic [6:0] d1, logic [6:0] d2, logic [1:0] len);
      out_word_t  m;
      logic [3:0] kind;
      kind       = run_status[p] - ST_NOTE_OFF;
      m.src_port = p[PORT_W-1:0];
      m.msg_kind = kind[2:0];
      m.chan     = run_chan[p];
      m.data_one = d1;
      m.data_two = d2;
      m.msg_len  = len;
      m.seq_num  = seq_count[p];
      seq_count[p] = seq_count[p] + 16'd1;
      expected_msgs.push_back(m);
    endfunction

    function void note_byte(in_word_t w);
      int unsigned p;
      p = {30'd0, w.port};
      if (p >= NUM_PORTS) return;
      if (w.rx_byte[7]) begin
        run_chan[p]   = w.rx_byte[3:0];
        run_status[p] = (w.rx_byte == BYTE_EOX) ? ST_NONE : w.rx_byte[7:4];
        pend_valid[p] = 1'b0;
        return;
      end
      case (run_status[p])
        ST_PROGRAM, ST_CHAN_PRESS: begin
          push_msg(p, w.rx_byte[6:0], 7'd0, LEN_SHORT);
        end
        ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CONTROL, ST_PITCH: begin
          if (pend_valid[p]) begin
            pend_valid[p] = 1'b0;
            push_msg(p, pend_byte[p], w.rx_byte[6:0], LEN_LONG);
          end else begin
            pend_byte[p]  = w.rx_byte[6:0];
            pend_valid[p] = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want, logic [15:0] seq);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h want %0h (seq %0d)", name, got, want, seq));
    endtask

    task check_msg(out_word_t got);
      out_word_t want;
      if (expected_msgs.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
        return;
      end
      want = expected_msgs.pop_front();
      check_field("src_port", 16'(got.src_port), 16'(want.src_port), want.seq_num);
      check_field("msg_kind", 16'(got.msg_kind), 16'(want.msg_kind), want.seq_num);
      check_field("chan", 16'(got.chan), 16'(want.chan), want.seq_num);
      check_field("data_one", 16'(got.data_one), 16'(want.data_one), want.seq_num);
      check_field("data_two", 16'(got.data_two), 16'(want.data_two), want.seq_num);
      check_field("msg_len", 16'(got.msg_len), 16'(want.msg_len), want.seq_num);
      check_field("seq_num", got.seq_num, want.seq_num, want.seq_num);
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_word_t  byte_word = '0;
  logic      msg_valid;
  logic      msg_ready = 1'b0;
  out_word_t msg_word;

  msg_scoreboard sb = new();
  int            items_sent = 0;
  int            stall_left = 0;

  midi_running_status_parser_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_word  (byte_word),
    .msg_valid  (msg_valid),
    .msg_ready  (msg_ready),
    .msg_word   (msg_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait();
    if ($urandom_range(0, 4) == 0) return 0;
    return int'($urandom_range(0, 17));
  endfunction

  always @(posedge clk) begin : msg_sink
    int n;
    if (rst) begin
      msg_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (msg_valid && msg_ready) sb.check_msg(msg_word);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        msg_ready  <= (stall_left == 1);
      end else if (msg_valid && msg_ready) begin
        n = draw_wait();
        stall_left <= n;
        msg_ready  <= (n == 0);
      end else begin
        msg_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [1:0] p, input logic [7:0] b);
    int       gap;
    in_word_t w;
    gap       = draw_wait();
    w.port    = p;
    w.rx_byte = b;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_word  <= w;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sb.note_byte(w);
    items_sent++;
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_msgs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    #6_000_000;
    $display("FAIL midi_running_status_parser_unit");
    $finish;
  end

  initial begin : stimulus
    logic [1:0] p;
    logic [2:0] cls;
    logic [3:0] ch;
    logic [6:0] d;
    int         pick;
    int         n;
    bit         paused;
    paused = 1'b0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drop data with no status, under system status and after end of exclusive; then mix messages across ports
    send_byte(2'd0, 8'h05);
    send_byte(2'd0, 8'hF0);
    send_byte(2'd0, 8'h10);
    send_byte(2'd0, 8'hF7);
    send_byte(2'd0, 8'h11);
    send_byte(2'd0, 8'h90);
    send_byte(2'd0, 8'h00);
    send_byte(2'd0, 8'h7F);
    send_byte(2'd0, 8'h40);
    send_byte(2'd1, 8'h85);
    send_byte(2'd0, 8'h8F);
    send_byte(2'd1, 8'h7F);
    send_byte(2'd1, 8'h00);
    send_byte(2'd2, 8'hC3);
    send_byte(2'd2, 8'h00);
    send_byte(2'd2, 8'h7F);
    send_byte(2'd3, 8'hDF);
    send_byte(2'd3, 8'h55);
    send_byte(2'd3, 8'hAA);
    send_byte(2'd3, 8'h01);
    send_byte(2'd3, 8'h02);
    send_byte(2'd1, 8'hBC);
    send_byte(2'd1, 8'h07);
    send_byte(2'd1, 8'hF8);
    send_byte(2'd1, 8'h12);
    send_byte(2'd2, 8'hE1);
    send_byte(2'd2, 8'h00);
    send_byte(2'd2, 8'h40);
    send_byte(2'd0, 8'hFF);
    send_byte(2'd0, 8'h2A);
    drain();

    while (items_sent < 1050) begin
      pick = int'($urandom_range(0, 99));
      p    = 2'($urandom_range(0, 3));
      if (pick < 70) begin
        cls = 3'($urandom_range(0, 6));
        ch  = 4'($urandom_range(0, 15));
        send_byte(p, {1'b1, cls, ch});
        n = int'($urandom_range(1, 7));
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) begin
            send_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          end else begin
            d = 7'($urandom_range(0, 127));
            send_byte(p, {1'b0, d});
          end
        end
      end else if (pick < 85) begin
        send_byte(p, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        ch = 4'($urandom_range(0, 15));
        send_byte(p, {4'hF, ch});
      end else begin
        d = 7'($urandom_range(0, 127));
        send_byte(p, {1'b0, d});
      end
      if (!paused && items_sent >= 500) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();

    send_byte(2'd2, 8'hF7);
    send_byte(2'd2, 8'h33);
    drain();

    if (sb.errors == 0 && sb.expected_msgs.size() == 0) begin
      $display("PASS midi_running_status_parser_unit");
    end else begin
      $display("FAIL midi_running_status_parser_unit");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mrsp_pkg.sv
rtl/core/mrsp_step.sv
rtl/core/midi_running_status_parser_unit.sv
rtl/core/mrsp_checker.sv
bench/tb_top.sv
